/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// types, codes and helper functions of the json string unescape unit
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int MAX_ITEMS = 6;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int CP_W      = 21;

    // decoder phase
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_BODY     = 4'd1,
        PH_ESC      = 4'd2,
        PH_HEX      = 4'd3,
        PH_AHIGH    = 4'd4,
        PH_AHIGH_BS = 4'd5,
        PH_LOW_HEX  = 4'd6,
        PH_SCAN     = 4'd7,
        PH_SCAN_ESC = 4'd8
    } phase_t;

    // status of the closing beat
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_QUOTE = 3'd1,
        ST_TRUNC    = 3'd2,
        ST_UNTERM   = 3'd3,
        ST_BAD_UNI  = 3'd4,
        ST_BAD_ESC  = 3'd5
    } status_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] hex_accum;
        logic [1:0]  hex_count;
        logic [15:0] held_high;
        logic        high_pending;
        status_t     saved_error;
    } dec_state_t;

    localparam dec_state_t STATE_RESET = '{
        phase:        PH_IDLE,
        hex_accum:    16'h0000,
        hex_count:    2'd0,
        held_high:    16'h0000,
        high_pending: 1'b0,
        saved_error:  ST_OK
    };

    // one result beat
    typedef struct packed {
        logic [7:0] data;
        logic       is_byte;
        logic       last;
        status_t    status;
    } item_t;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } utf8_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_TAB = 8'h09;

    // surrogate ranges and encoding limits
    localparam logic [15:0]     HI_MIN    = 16'hD800;
    localparam logic [15:0]     HI_MAX    = 16'hDBFF;
    localparam logic [15:0]     LO_MIN    = 16'hDC00;
    localparam logic [15:0]     LO_MAX    = 16'hDFFF;
    localparam logic [CP_W-1:0] PLANE1    = 21'h10000;
    localparam logic [CP_W-1:0] LIM_1BYTE = 21'h00080;
    localparam logic [CP_W-1:0] LIM_2BYTE = 21'h00800;

    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t r;
        r.ok  = 1'b1;
        r.val = 4'd0;
        if (c inside {[8'h30:8'h39]})
            r.val = c[3:0];
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
            r.val = c[3:0] + 4'd9;
        else
            r.ok = 1'b0;
        return r;
    endfunction

    // b[0] is the first byte sent
    function automatic utf8_t utf8_enc(input logic [CP_W-1:0] cp);
        utf8_t r;
        r.b   = '0;
        r.len = 3'd1;
        if (cp < LIM_1BYTE) begin
            r.b[0] = cp[7:0];
        end
        else if (cp < LIM_2BYTE) begin
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
            r.len  = 3'd2;
        end
        else if (cp < PLANE1) begin
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
            r.len  = 3'd3;
        end
        else begin
            r.b[0] = {5'b11110, cp[20:18]};
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
            r.len  = 3'd4;
        end
        return r;
    endfunction

    function automatic item_t byte_item(input logic [7:0] b);
        item_t r;
        r.data    = b;
        r.is_byte = 1'b1;
        r.last    = 1'b0;
        r.status  = ST_OK;
        return r;
    endfunction

    function automatic item_t final_item(input status_t st);
        item_t r;
        r.data    = 8'h00;
        r.is_byte = 1'b0;
        r.last    = 1'b1;
        r.status  = st;
        return r;
    endfunction

endpackage

/* rtl/jsu_step.sv */
// ----------------------------------------------------------------------------
// jsu_step
// next decoder state and the list of result beats for one input byte
// ----------------------------------------------------------------------------
module jsu_step (
    input  jsu_pkg::dec_state_t                     cur,
    input  logic [7:0]                              in_byte,
    output jsu_pkg::dec_state_t                     nxt,
    output jsu_pkg::item_t [jsu_pkg::MAX_ITEMS-1:0] items,
    output logic [jsu_pkg::CNT_W-1:0]               item_cnt
);

    jsu_pkg::hex_t              hx;
    logic [15:0]                acc;
    logic                       flush;
    logic                       route_en;
    jsu_pkg::phase_t            route;
    logic                       t_byte;
    logic                       t_cp;
    logic                       t_final;
    logic [7:0]                 t_data;
    logic [jsu_pkg::CP_W-1:0]   t_cp_val;
    jsu_pkg::status_t           t_status;
    jsu_pkg::utf8_t             fl_enc;
    jsu_pkg::utf8_t             tl_enc;
    jsu_pkg::item_t [3:0]       tail;
    logic [jsu_pkg::CNT_W-1:0]  tail_n;
    logic [jsu_pkg::CNT_W-1:0]  flush_n;
    logic [jsu_pkg::CNT_W-1:0]  j;

    assign hx  = jsu_pkg::hex_digit(in_byte);
    assign acc = {cur.hex_accum[11:0], hx.val};

    always_comb
    begin
        nxt      = cur;
        flush    = 1'b0;
        route_en = 1'b1;
        route    = cur.phase;
        t_byte   = 1'b0;
        t_cp     = 1'b0;
        t_final  = 1'b0;
        t_data   = 8'h00;
        t_cp_val = '0;
        t_status = jsu_pkg::ST_OK;

        // first pass: phases that may hand the byte on to a plain phase
        case (cur.phase)
            jsu_pkg::PH_AHIGH:
            begin
                if (in_byte == jsu_pkg::CH_BSLASH)
                begin
                    nxt.phase = jsu_pkg::PH_AHIGH_BS;
                    route_en  = 1'b0;
                end
                else
                begin
                    flush = 1'b1;
                    route = jsu_pkg::PH_BODY;
                end
            end
            jsu_pkg::PH_AHIGH_BS:
            begin
                if (in_byte == jsu_pkg::CH_U)
                begin
                    nxt.hex_accum = '0;
                    nxt.hex_count = '0;
                    nxt.phase     = jsu_pkg::PH_LOW_HEX;
                    route_en      = 1'b0;
                end
                else
                begin
                    flush = 1'b1;
                    route = jsu_pkg::PH_ESC;
                end
            end
            jsu_pkg::PH_HEX, jsu_pkg::PH_LOW_HEX:
            begin
                if (!hx.ok)
                begin
                    // bad digit: error, then scan this byte as a plain one
                    flush           = 1'b1;
                    nxt.saved_error = jsu_pkg::ST_BAD_UNI;
                    nxt.hex_accum   = '0;
                    nxt.hex_count   = '0;
                    route           = jsu_pkg::PH_SCAN;
                end
                else
                begin
                    route_en = 1'b0;
                    if (cur.hex_count != 2'd3)
                    begin
                        nxt.hex_accum = acc;
                        nxt.hex_count = cur.hex_count + 2'd1;
                    end
                    else
                    begin
                        nxt.hex_accum = '0;
                        nxt.hex_count = '0;
                        if (cur.phase == jsu_pkg::PH_LOW_HEX &&
                            acc inside {[jsu_pkg::LO_MIN:jsu_pkg::LO_MAX]})
                        begin
                            // join the surrogate pair
                            nxt.high_pending = 1'b0;
                            nxt.held_high    = '0;
                            t_cp             = 1'b1;
                            t_cp_val         = jsu_pkg::PLANE1 +
                                jsu_pkg::CP_W'({cur.held_high[9:0], acc[9:0]});
                            nxt.phase        = jsu_pkg::PH_BODY;
                        end
                        else
                        begin
                            flush = 1'b1;
                            if (acc inside {[jsu_pkg::HI_MIN:jsu_pkg::HI_MAX]})
                            begin
                                nxt.held_high    = acc;
                                nxt.high_pending = 1'b1;
                                nxt.phase        = jsu_pkg::PH_AHIGH;
                            end
                            else
                            begin
                                nxt.held_high    = '0;
                                nxt.high_pending = 1'b0;
                                t_cp             = 1'b1;
                                t_cp_val         = jsu_pkg::CP_W'(acc);
                                nxt.phase        = jsu_pkg::PH_BODY;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (flush && route_en)
        begin
            nxt.high_pending = 1'b0;
            nxt.held_high    = '0;
        end

        // second pass: plain phases
        if (route_en)
        begin
            case (route)
                jsu_pkg::PH_IDLE:
                begin
                    if (in_byte == jsu_pkg::CH_QUOTE)
                        nxt.phase = jsu_pkg::PH_BODY;
                    else
                    begin
                        t_final  = 1'b1;
                        t_status = jsu_pkg::ST_NO_QUOTE;
                    end
                end
                jsu_pkg::PH_BODY:
                begin
                    if (in_byte == jsu_pkg::CH_NUL)
                    begin
                        t_final  = 1'b1;
                        t_status = jsu_pkg::ST_UNTERM;
                    end
                    else if (in_byte == jsu_pkg::CH_QUOTE)
                    begin
                        t_final  = 1'b1;
                        t_status = jsu_pkg::ST_OK;
                    end
                    else if (in_byte == jsu_pkg::CH_BSLASH)
                        nxt.phase = jsu_pkg::PH_ESC;
                    else
                    begin
                        t_byte    = 1'b1;
                        t_data    = in_byte;
                        nxt.phase = jsu_pkg::PH_BODY;
                    end
                end
                jsu_pkg::PH_ESC:
                begin
                    nxt.phase = jsu_pkg::PH_BODY;
                    case (in_byte)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
                        begin
                            t_byte = 1'b1;
                            t_data = in_byte;
                        end
                        jsu_pkg::CH_B:
                        begin
                            t_byte = 1'b1;
                            t_data = jsu_pkg::CTL_BS;
                        end
                        jsu_pkg::CH_F:
                        begin
                            t_byte = 1'b1;
                            t_data = jsu_pkg::CTL_FF;
                        end
                        jsu_pkg::CH_N:
                        begin
                            t_byte = 1'b1;
                            t_data = jsu_pkg::CTL_LF;
                        end
                        jsu_pkg::CH_R:
                        begin
                            t_byte = 1'b1;
                            t_data = jsu_pkg::CTL_CR;
                        end
                        jsu_pkg::CH_T:
                        begin
                            t_byte = 1'b1;
                            t_data = jsu_pkg::CTL_TAB;
                        end
                        jsu_pkg::CH_U:
                        begin
                            nxt.hex_accum = '0;
                            nxt.hex_count = '0;
                            nxt.phase     = jsu_pkg::PH_HEX;
                        end
                        jsu_pkg::CH_NUL:
                        begin
                            t_final  = 1'b1;
                            t_status = jsu_pkg::ST_TRUNC;
                        end
                        default:
                        begin
                            nxt.saved_error = jsu_pkg::ST_BAD_ESC;
                            nxt.hex_accum   = '0;
                            nxt.hex_count   = '0;
                            nxt.phase       = jsu_pkg::PH_SCAN;
                        end
                    endcase
                end
                jsu_pkg::PH_SCAN:
                begin
                    if (in_byte == jsu_pkg::CH_NUL)
                    begin
                        t_final  = 1'b1;
                        t_status = jsu_pkg::ST_UNTERM;
                    end
                    else if (in_byte == jsu_pkg::CH_QUOTE)
                    begin
                        t_final  = 1'b1;
                        t_status = nxt.saved_error;
                    end
                    else if (in_byte == jsu_pkg::CH_BSLASH)
                        nxt.phase = jsu_pkg::PH_SCAN_ESC;
                    else
                        nxt.phase = jsu_pkg::PH_SCAN;
                end
                jsu_pkg::PH_SCAN_ESC:
                begin
                    if (in_byte == jsu_pkg::CH_NUL)
                    begin
                        t_final  = 1'b1;
                        t_status = jsu_pkg::ST_TRUNC;
                    end
                    else
                        nxt.phase = jsu_pkg::PH_SCAN;
                end
                default:
                    nxt = jsu_pkg::STATE_RESET;
            endcase
        end

        if (t_final)
            nxt = jsu_pkg::STATE_RESET;
    end

    // result list: flushed high surrogate first, then the tail
    assign fl_enc = jsu_pkg::utf8_enc(jsu_pkg::CP_W'(cur.held_high));
    assign tl_enc = jsu_pkg::utf8_enc(t_cp_val);

    always_comb
    begin
        tail   = '0;
        tail_n = '0;
        if (t_final)
        begin
            tail[0] = jsu_pkg::final_item(t_status);
            tail_n  = jsu_pkg::CNT_W'(1);
        end
        else if (t_byte)
        begin
            tail[0] = jsu_pkg::byte_item(t_data);
            tail_n  = jsu_pkg::CNT_W'(1);
        end
        else if (t_cp)
        begin
            for (int k = 0; k < 4; k++)
                tail[k] = jsu_pkg::byte_item(tl_enc.b[k]);
            tail_n = jsu_pkg::CNT_W'(tl_enc.len);
        end
    end

    assign flush_n  = (flush && cur.high_pending) ? jsu_pkg::CNT_W'(fl_enc.len) : '0;
    assign item_cnt = flush_n + tail_n;

    always_comb
    begin
        items = '0;
        j     = '0;
        for (int i = 0; i < jsu_pkg::MAX_ITEMS; i++)
        begin
            j = jsu_pkg::CNT_W'(i) - flush_n;
            if (jsu_pkg::CNT_W'(i) < flush_n)
                items[i] = jsu_pkg::byte_item(fl_enc.b[i[1:0]]);
            else if (j < tail_n)
                items[i] = tail[j[1:0]];
        end
    end

endmodule

/* rtl/json_string_unescape_utf8_unit.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// streaming unescape of one json string literal into utf-8 bytes
// ----------------------------------------------------------------------------
// The unit takes one text byte per beat (0 ends the text), expects an opening
// quote, passes plain bytes through, turns simple escapes and \uXXXX escapes
// into utf-8, joins a high/low surrogate pair into one four-byte code point
// and sends a lone surrogate in three-byte form. Every string ends with one
// closing beat (last set, byte_valid clear) carrying the status: 0 ok, 1 no
// opening quote, 2 truncated escape, 3 unterminated, 4 bad unicode escape,
// 5 bad escape; on a non-zero status the consumer drops the bytes already
// sent. Each input byte is decoded in the cycle it is accepted and its 0 to 6
// result beats are parked in a small result buffer that drains one beat per
// cycle while out_stall is low. The input side takes a byte every cycle as
// long as each byte yields at most one beat and the output does not stall; a
// byte with more beats holds the input until its last beat leaves the buffer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module json_string_unescape_utf8_unit (
    input  logic       clk,
    input  logic       rst_n,

    // text input
    input  logic       text_valid,
    output logic       text_stall,
    input  logic [7:0] text_byte,

    // decoded output
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last,
    output logic [2:0] status
);

    jsu_pkg::dec_state_t                     state_reg;
    jsu_pkg::dec_state_t                     state_next;
    jsu_pkg::item_t [jsu_pkg::MAX_ITEMS-1:0] step_items;
    logic [jsu_pkg::CNT_W-1:0]               step_cnt;

    // result buffer: items_reg holds the beats of the last accepted byte,
    // cnt_reg counts the ones still to go, rd_reg points at the next one
    jsu_pkg::item_t [jsu_pkg::MAX_ITEMS-1:0] items_reg;
    logic [jsu_pkg::CNT_W-1:0]               cnt_reg;
    logic [jsu_pkg::CNT_W-1:0]               cnt_next;
    logic [jsu_pkg::CNT_W-1:0]               rd_reg;
    logic [jsu_pkg::CNT_W-1:0]               rd_next;

    logic           in_take;
    logic           out_take;
    jsu_pkg::item_t head;

    jsu_step u_step (
        .cur      (state_reg),
        .in_byte  (text_byte),
        .nxt      (state_next),
        .items    (step_items),
        .item_cnt (step_cnt)
    );

    // room for a new byte once the buffer is empty or its last beat leaves now
    assign out_take   = out_valid && !out_stall;
    assign text_stall = (cnt_reg > jsu_pkg::CNT_W'(1)) ||
                        (cnt_reg == jsu_pkg::CNT_W'(1) && out_stall);
    assign in_take    = text_valid && !text_stall;

    always_comb
    begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (in_take)
        begin
            cnt_next = step_cnt;
            rd_next  = '0;
        end
        else if (out_take)
        begin
            cnt_next = cnt_reg - jsu_pkg::CNT_W'(1);
            rd_next  = rd_reg + jsu_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jsu_pkg::STATE_RESET;
            cnt_reg   <= '0;
            rd_reg    <= '0;
        end
        else
        begin
            if (in_take)
                state_reg <= state_next;
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
    end

    // beat payloads need no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
            items_reg <= step_items;
    end

    assign head       = items_reg[rd_reg];
    assign out_valid  = (cnt_reg != '0);
    assign out_byte   = head.data;
    assign byte_valid = head.is_byte;
    assign last       = head.last;
    assign status     = head.status;

    // the closing beat is always the final one of its byte's list
    `ASSERT_SAME(a_last_is_tail, out_valid && last, cnt_reg == jsu_pkg::CNT_W'(1))

    // while a closing beat waits, the decoder has already gone back to idle
    `ASSERT_SAME(a_idle_at_close, out_valid && last,
                 state_reg.phase == jsu_pkg::PH_IDLE && !state_reg.high_pending)

    // data beats carry a byte and a clean status
    `ASSERT_SAME(a_data_beat, out_valid && !last,
                 byte_valid && status == jsu_pkg::ST_OK)

    // the buffer never holds more beats than one byte can produce
    `ASSERT_NEXT(a_cnt_bound, in_take,
                 cnt_reg <= jsu_pkg::CNT_W'(jsu_pkg::MAX_ITEMS))

endmodule

/* tb/tb_json_string_unescape_utf8_unit.sv */
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8_unit
// self-checking bench for the json string unescape unit
// ----------------------------------------------------------------------------
// A short directed prelude is followed by random strings built from typed
// tokens: plain bytes, simple escapes, \u escapes, surrogate pairs, lone
// surrogates, bad escapes and broken \u digits. A behavioral decoder predicts
// the result beats of every accepted text byte. The monitor compares each
// accepted output beat field by field against the oldest prediction. Both
// handshakes idle at random, and twice the receiver holds off for a long
// stretch so that the result buffer fills and the unit stalls its input.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_unit;

    localparam int RANDOM_BYTES = 380;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 30;

    // hex digit characters
    localparam logic [7:0] DIG_0    = 8'h30;
    localparam logic [7:0] DIG_9    = 8'h39;
    localparam logic [7:0] HEX_LO_A = 8'h61;
    localparam logic [7:0] HEX_LO_F = 8'h66;
    localparam logic [7:0] HEX_UP_A = 8'h41;
    localparam logic [7:0] HEX_UP_F = 8'h46;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       text_valid = 1'b0;
    logic       text_stall;
    logic [7:0] text_byte  = 8'h00;
    logic       out_valid;
    logic       out_stall  = 1'b1;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic [2:0] status;

    json_string_unescape_utf8_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_byte  (text_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .last       (last),
        .status     (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // shared bench state
    // ------------------------------------------------------------------------
    logic [7:0]      text_q[$];          // text bytes waiting to be offered
    jsu_pkg::item_t  expected_beats[$];  // predicted result beats, oldest first
    int              fail_count  = 0;
    int              bytes_sent  = 0;    // accepted text beats, updated at the edge
    int              cycle_cnt   = 0;
    int              idle_cycles = 0;
    logic            pressure_on = 1'b0; // receiver is in a long hold-off
    logic            calm;

    // some windows run with no idling at all on either side
    assign calm = (cycle_cnt % 500) < 120;

    // ------------------------------------------------------------------------
    // decoder shadow state
    // ------------------------------------------------------------------------
    jsu_pkg::phase_t  dec_phase = jsu_pkg::PH_IDLE;
    logic [15:0]      hex_acc   = 16'h0000;
    logic [1:0]       hex_cnt   = 2'd0;
    logic [15:0]      held_hi   = 16'h0000;
    logic             hi_pend   = 1'b0;
    jsu_pkg::status_t err_code  = jsu_pkg::ST_OK;

    function automatic void clear_decoder();
        dec_phase = jsu_pkg::PH_IDLE;
        hex_acc   = 16'h0000;
        hex_cnt   = 2'd0;
        held_hi   = 16'h0000;
        hi_pend   = 1'b0;
        err_code  = jsu_pkg::ST_OK;
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        jsu_pkg::item_t r;
        r.data    = b;
        r.is_byte = 1'b1;
        r.last    = 1'b0;
        r.status  = jsu_pkg::ST_OK;
        expected_beats.push_back(r);
    endfunction

    // closing beat; the decoder goes back to waiting for a quote
    function automatic void close_string(input jsu_pkg::status_t st);
        jsu_pkg::item_t r;
        r.data    = 8'h00;
        r.is_byte = 1'b0;
        r.last    = 1'b1;
        r.status  = st;
        expected_beats.push_back(r);
        clear_decoder();
    endfunction

    function automatic void emit_code_point(input logic [20:0] cp);
        if (cp < jsu_pkg::LIM_1BYTE)
            emit_byte(cp[7:0]);
        else if (cp < jsu_pkg::LIM_2BYTE)
        begin
            emit_byte({3'b110, cp[10:6]});
            emit_byte({2'b10, cp[5:0]});
        end
        else if (cp < jsu_pkg::PLANE1)
        begin
            emit_byte({4'b1110, cp[15:12]});
            emit_byte({2'b10, cp[11:6]});
            emit_byte({2'b10, cp[5:0]});
        end
        else
        begin
            emit_byte({5'b11110, cp[20:18]});
            emit_byte({2'b10, cp[17:12]});
            emit_byte({2'b10, cp[11:6]});
            emit_byte({2'b10, cp[5:0]});
        end
    endfunction

    function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= DIG_0 && c <= DIG_9)
        begin
            v = 4'(c - DIG_0);
            return 1'b1;
        end
        if (c >= HEX_LO_A && c <= HEX_LO_F)
        begin
            v = 4'(c - HEX_LO_A + 8'd10);
            return 1'b1;
        end
        if (c >= HEX_UP_A && c <= HEX_UP_F)
        begin
            v = 4'(c - HEX_UP_A + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // a held high surrogate that found no low partner goes out on its own
    function automatic void release_high();
        if (hi_pend)
            emit_code_point({5'd0, held_hi});
        hi_pend = 1'b0;
        held_hi = 16'h0000;
    endfunction

    // once a decode error is seen only the end of the string matters
    function automatic void scan_step(input logic [7:0] b);
        if (b == jsu_pkg::CH_NUL)
            close_string(jsu_pkg::ST_UNTERM);
        else if (b == jsu_pkg::CH_QUOTE)
            close_string(err_code);
        else if (b == jsu_pkg::CH_BSLASH)
            dec_phase = jsu_pkg::PH_SCAN_ESC;
        else
            dec_phase = jsu_pkg::PH_SCAN;
    endfunction

    function automatic void start_error(input jsu_pkg::status_t code);
        err_code  = code;
        hex_acc   = 16'h0000;
        hex_cnt   = 2'd0;
        dec_phase = jsu_pkg::PH_SCAN;
    endfunction

    function automatic void body_step(input logic [7:0] b);
        if (b == jsu_pkg::CH_NUL)
            close_string(jsu_pkg::ST_UNTERM);
        else if (b == jsu_pkg::CH_QUOTE)
            close_string(jsu_pkg::ST_OK);
        else if (b == jsu_pkg::CH_BSLASH)
            dec_phase = jsu_pkg::PH_ESC;
        else
        begin
            emit_byte(b);
            dec_phase = jsu_pkg::PH_BODY;
        end
    endfunction

    // a finished \u unit that is not the low half of a pair
    function automatic void take_unit(input logic [15:0] u);
        if (u >= jsu_pkg::HI_MIN && u <= jsu_pkg::HI_MAX)
        begin
            held_hi   = u;
            hi_pend   = 1'b1;
            dec_phase = jsu_pkg::PH_AHIGH;
        end
        else
        begin
            emit_code_point({5'd0, u});
            dec_phase = jsu_pkg::PH_BODY;
        end
    endfunction

    function automatic void escape_step(input logic [7:0] c);
        case (c)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
            begin
                emit_byte(c);
                dec_phase = jsu_pkg::PH_BODY;
            end
            jsu_pkg::CH_B:
            begin
                emit_byte(jsu_pkg::CTL_BS);
                dec_phase = jsu_pkg::PH_BODY;
            end
            jsu_pkg::CH_F:
            begin
                emit_byte(jsu_pkg::CTL_FF);
                dec_phase = jsu_pkg::PH_BODY;
            end
            jsu_pkg::CH_N:
            begin
                emit_byte(jsu_pkg::CTL_LF);
                dec_phase = jsu_pkg::PH_BODY;
            end
            jsu_pkg::CH_R:
            begin
                emit_byte(jsu_pkg::CTL_CR);
                dec_phase = jsu_pkg::PH_BODY;
            end
            jsu_pkg::CH_T:
            begin
                emit_byte(jsu_pkg::CTL_TAB);
                dec_phase = jsu_pkg::PH_BODY;
            end
            jsu_pkg::CH_U:
            begin
                hex_acc   = 16'h0000;
                hex_cnt   = 2'd0;
                dec_phase = jsu_pkg::PH_HEX;
            end
            jsu_pkg::CH_NUL:
                close_string(jsu_pkg::ST_TRUNC);
            default:
                start_error(jsu_pkg::ST_BAD_ESC);
        endcase
    endfunction

    // expected beats for one accepted text byte
    function automatic void decode_text_byte(input logic [7:0] b);
        logic [3:0]  nib;
        logic [15:0] hi_off;
        logic [20:0] cp;
        case (dec_phase)
            jsu_pkg::PH_IDLE:
                if (b == jsu_pkg::CH_QUOTE)
                    dec_phase = jsu_pkg::PH_BODY;
                else
                    close_string(jsu_pkg::ST_NO_QUOTE);
            jsu_pkg::PH_BODY:
                body_step(b);
            jsu_pkg::PH_ESC:
                escape_step(b);
            jsu_pkg::PH_HEX, jsu_pkg::PH_LOW_HEX:
            begin
                if (!hex_nibble(b, nib))
                begin
                    // the offending byte is rescanned, so it may end the string
                    release_high();
                    start_error(jsu_pkg::ST_BAD_UNI);
                    scan_step(b);
                end
                else
                begin
                    hex_acc = {hex_acc[11:0], nib};
                    if (hex_cnt != 2'd3)
                        hex_cnt = hex_cnt + 2'd1;
                    else
                    begin
                        hex_cnt = 2'd0;
                        if (dec_phase == jsu_pkg::PH_LOW_HEX &&
                            hex_acc >= jsu_pkg::LO_MIN && hex_acc <= jsu_pkg::LO_MAX)
                        begin
                            hi_off = held_hi - jsu_pkg::HI_MIN;
                            cp = jsu_pkg::PLANE1 + (21'(hi_off) << 10) +
                                 21'(hex_acc - jsu_pkg::LO_MIN);
                            hi_pend   = 1'b0;
                            held_hi   = 16'h0000;
                            emit_code_point(cp);
                            dec_phase = jsu_pkg::PH_BODY;
                        end
                        else
                        begin
                            release_high();
                            take_unit(hex_acc);
                        end
                        hex_acc = 16'h0000;
                    end
                end
            end
            jsu_pkg::PH_AHIGH:
                if (b == jsu_pkg::CH_BSLASH)
                    dec_phase = jsu_pkg::PH_AHIGH_BS;
                else
                begin
                    release_high();
                    body_step(b);
                end
            jsu_pkg::PH_AHIGH_BS:
                if (b == jsu_pkg::CH_U)
                begin
                    hex_acc   = 16'h0000;
                    hex_cnt   = 2'd0;
                    dec_phase = jsu_pkg::PH_LOW_HEX;
                end
                else
                begin
                    release_high();
                    escape_step(b);
                end
            jsu_pkg::PH_SCAN:
                scan_step(b);
            jsu_pkg::PH_SCAN_ESC:
                if (b == jsu_pkg::CH_NUL)
                    close_string(jsu_pkg::ST_TRUNC);
                else
                    dec_phase = jsu_pkg::PH_SCAN;
            default:
                clear_decoder();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------
    function automatic void add_byte(input logic [7:0] b);
        text_q.push_back(b);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return DIG_0 + {4'd0, nib};
        if ($urandom_range(0, 1) == 1)
            return HEX_UP_A + {4'd0, nib} - 8'd10;
        return HEX_LO_A + {4'd0, nib} - 8'd10;
    endfunction

    // \u escape with four digits in mixed case
    function automatic void add_unicode(input logic [15:0] v);
        logic [15:0] rest;
        rest = v;
        add_byte(jsu_pkg::CH_BSLASH);
        add_byte(jsu_pkg::CH_U);
        repeat (4)
        begin
            add_byte(hex_char(rest[15:12]));
            rest = rest << 4;
        end
    endfunction

    function automatic logic [7:0] escape_letter(input int unsigned idx);
        case (idx)
            0:       return jsu_pkg::CH_QUOTE;
            1:       return jsu_pkg::CH_BSLASH;
            2:       return jsu_pkg::CH_SLASH;
            3:       return jsu_pkg::CH_B;
            4:       return jsu_pkg::CH_F;
            5:       return jsu_pkg::CH_N;
            6:       return jsu_pkg::CH_R;
            default: return jsu_pkg::CH_T;
        endcase
    endfunction

    function automatic logic is_escape_letter(input logic [7:0] c);
        case (c)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH, jsu_pkg::CH_B,
            jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R, jsu_pkg::CH_T, jsu_pkg::CH_U:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic void add_random_token();
        int unsigned sel;
        int unsigned k;
        logic [7:0]  b;
        logic [15:0] v;
        logic [3:0]  nib;
        logic        bad;
        sel = $urandom_range(0, 99);
        if (sel < 35)
        begin
            // plain byte, anything but NUL, the quote and the backslash
            do
                b = 8'($urandom_range(1, 255));
            while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
            add_byte(b);
        end
        else if (sel < 50)
        begin
            add_byte(jsu_pkg::CH_BSLASH);
            add_byte(escape_letter($urandom_range(0, 7)));
        end
        else if (sel < 65)
        begin
            // single \u across the utf-8 length classes and lone low halves
            case ($urandom_range(0, 4))
                0:       v = 16'($urandom_range(0, 'h7F));
                1:       v = 16'($urandom_range('h80, 'h7FF));
                2:       v = 16'($urandom_range('h800, 'hFFFF));
                3:       v = 16'($urandom_range(jsu_pkg::LO_MIN, jsu_pkg::LO_MAX));
                default: v = 16'($urandom());
            endcase
            add_unicode(v);
        end
        else if (sel < 78)
        begin
            add_unicode(16'($urandom_range(jsu_pkg::HI_MIN, jsu_pkg::HI_MAX)));
            add_unicode(16'($urandom_range(jsu_pkg::LO_MIN, jsu_pkg::LO_MAX)));
        end
        else if (sel < 86)
            // lone high half; whatever token follows decides its fate
            add_unicode(16'($urandom_range(jsu_pkg::HI_MIN, jsu_pkg::HI_MAX)));
        else if (sel < 93)
        begin
            do
                b = 8'($urandom_range(1, 255));
            while (is_escape_letter(b));
            add_byte(jsu_pkg::CH_BSLASH);
            add_byte(b);
        end
        else
        begin
            // \u cut short by a non-hex byte, sometimes after a high half
            if ($urandom_range(0, 1) == 1)
                add_unicode(16'($urandom_range(jsu_pkg::HI_MIN, jsu_pkg::HI_MAX)));
            add_byte(jsu_pkg::CH_BSLASH);
            add_byte(jsu_pkg::CH_U);
            v = 16'($urandom());
            k = $urandom_range(0, 3);
            repeat (k)
            begin
                add_byte(hex_char(v[15:12]));
                v = v << 4;
            end
            do
            begin
                b   = 8'($urandom_range(0, 255));
                bad = !hex_nibble(b, nib);
            end
            while (!bad);
            add_byte(b);
        end
    endfunction

    function automatic void add_random_string();
        int unsigned r;
        logic [7:0]  b;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            // noise where an opening quote belongs
            do
                b = 8'($urandom_range(0, 255));
            while (b == jsu_pkg::CH_QUOTE);
            add_byte(b);
        end
        else
        begin
            add_byte(jsu_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 6))
                add_random_token();
            r = $urandom_range(0, 99);
            if (r < 80)
                add_byte(jsu_pkg::CH_QUOTE);
            else if (r < 88)
                add_byte(jsu_pkg::CH_NUL);
            else if (r < 95)
            begin
                add_byte(jsu_pkg::CH_BSLASH);
                add_byte(jsu_pkg::CH_NUL);
            end
            // otherwise left open: the next string runs into this one
        end
    endfunction

    // mostly short gaps, a few long ones, none in calm windows
    function automatic int unsigned pick_gap(input logic quiet);
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("error at %0t: %s got %0h expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    // ------------------------------------------------------------------------
    // text driver: predicts on every accepted beat, then offers the next byte
    // ------------------------------------------------------------------------
    int unsigned send_gap = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            text_valid <= 1'b0;
            text_byte  <= 8'h00;
        end
        else
        begin
            if (text_valid && !text_stall)
            begin
                decode_text_byte(text_byte);
                bytes_sent <= bytes_sent + 1;
            end
            if (text_valid && text_stall)
            begin
                // stalled beat stays as it is
            end
            else if (send_gap != 0)
            begin
                send_gap   = send_gap - 1;
                text_valid <= 1'b0;
            end
            else if (text_q.size() != 0)
            begin
                text_byte  <= text_q.pop_front();
                text_valid <= 1'b1;
                // keep offering while the receiver holds off
                send_gap = pick_gap(calm || pressure_on);
            end
            else
                text_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // result receiver: random stall plus two long hold-offs
    // ------------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;
    int          holds_done = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            pressure_on <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left   = hold_left - 1;
            out_stall   <= 1'b1;
            pressure_on <= 1'b1;
        end
        else if ((holds_done == 0 && bytes_sent >= 120) ||
                 (holds_done == 1 && bytes_sent >= 300))
        begin
            holds_done++;
            hold_left   = HOLD_CYCLES;
            out_stall   <= 1'b1;
            pressure_on <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left  = stall_left - 1;
            out_stall   <= 1'b1;
            pressure_on <= 1'b0;
        end
        else
        begin
            out_stall   <= 1'b0;
            pressure_on <= 1'b0;
            stall_left  = pick_gap(calm);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: every accepted result beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        jsu_pkg::item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("result beat with none pending, out_byte", out_byte, 0);
            else
            begin
                want = expected_beats.pop_front();
                if (out_byte !== want.data)
                    report_mismatch("out_byte", out_byte, want.data);
                if (byte_valid !== want.is_byte)
                    report_mismatch("byte_valid", byte_valid, want.is_byte);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long with no beat moving on either side
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (!rst_n || (text_valid && !text_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int stim_end;

        // directed: missing quote, including end of text in place of it
        add_byte(8'h78);
        add_byte(jsu_pkg::CH_NUL);
        // extreme bytes, a simple escape and a surrogate pair
        add_byte(jsu_pkg::CH_QUOTE);
        add_byte(8'hFF);
        add_byte(8'h01);
        add_byte(jsu_pkg::CH_BSLASH);
        add_byte(jsu_pkg::CH_T);
        add_unicode(16'hD83D);
        add_unicode(16'hDE00);
        add_byte(jsu_pkg::CH_QUOTE);
        // bad simple escape, then the scan finds the closing quote
        add_byte(jsu_pkg::CH_QUOTE);
        add_byte(jsu_pkg::CH_BSLASH);
        add_byte(8'h71);
        add_byte(jsu_pkg::CH_QUOTE);
        // backslash right before end of text
        add_byte(jsu_pkg::CH_QUOTE);
        add_byte(jsu_pkg::CH_BSLASH);
        add_byte(jsu_pkg::CH_NUL);

        stim_end = text_q.size() + RANDOM_BYTES;
        while (text_q.size() < stim_end)
            add_random_string();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (text_q.size() != 0 || text_valid || expected_beats.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
